// ===== hw/rtl/cfpf_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpf_pkg - shared definitions of the chained-form path follower
// fixed point constants, arctangent table, micro-op encoding and program
// ----------------------------------------------------------------------------
package cfpf_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_ITERS = 16;
	localparam int ACC_WIDTH    = 48;

	localparam int NITER     = (CORDIC_ITERS < 24) ? CORDIC_ITERS : 24;
	localparam int DIV_BITS  = 62 + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

	localparam logic signed [63:0] LIM_POS = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] LIM_NEG = -LIM_POS;
	localparam logic signed [63:0] ONE_Q   = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] ACC_MAX = (64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] ACC_MIN = -ACC_MAX - 64'sd1;
	localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

	localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
	localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
	localparam logic signed [35:0] Q30_GAIN    = 36'sd652032874;

	localparam logic [29:0] ATAN_Q30 [24] = '{
		30'd843314857, 30'd497837829, 30'd263043836, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128
	};

	// configuration register indexes
	localparam logic [1:0] REG_GAIN_K0 = 2'd0;
	localparam logic [1:0] REG_GAIN_K2 = 2'd1;
	localparam logic [1:0] REG_GAIN_K3 = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SING = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	typedef enum logic [2:0] {
		OP_MUL, OP_DIV, OP_ADD, OP_ADDI, OP_ABS, OP_CHK, OP_END
	} op_t;

	typedef enum logic [4:0] {
		R_U1, R_D, R_C, R_CR, R_K0, R_K2, R_K3, R_ONE, R_INTG,
		R_SN, R_CS, R_DDOT, R_NUMS, R_DEN, R_SDOT, R_ABSV, R_SC, R_C2,
		R_T0, R_T1, R_T2, R_T3
	} opnd_t;

	typedef struct packed {
		op_t   op;
		opnd_t a;
		opnd_t b;
		opnd_t dst;
		logic  sh30;
		logic  neg;
	} uop_t;

	// response of an iterative unit
	typedef struct packed {
		logic              done;
		logic              sat;
		logic signed [63:0] res;
	} unit_rsp_t;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	// micro-program of the control law
	function automatic uop_t ucode(input logic [4:0] pc);
		uop_t u;
		u = '{OP_END, R_T0, R_T0, R_T0, 1'b0, 1'b0};
		unique case (pc)
			5'd0:  u = '{OP_MUL,  R_U1,   R_SN,   R_DDOT, 1'b1, 1'b0};
			5'd1:  u = '{OP_MUL,  R_U1,   R_CS,   R_NUMS, 1'b1, 1'b0};
			5'd2:  u = '{OP_MUL,  R_D,    R_C,    R_T0,   1'b0, 1'b1};
			5'd3:  u = '{OP_ADD,  R_ONE,  R_T0,   R_DEN,  1'b0, 1'b0};
			5'd4:  u = '{OP_CHK,  R_DEN,  R_DEN,  R_DEN,  1'b0, 1'b0};
			5'd5:  u = '{OP_DIV,  R_NUMS, R_DEN,  R_SDOT, 1'b0, 1'b0};
			5'd6:  u = '{OP_ABS,  R_SDOT, R_SDOT, R_ABSV, 1'b0, 1'b0};
			5'd7:  u = '{OP_MUL,  R_SDOT, R_D,    R_T0,   1'b0, 1'b0};
			5'd8:  u = '{OP_ADDI, R_INTG, R_T0,   R_INTG, 1'b0, 1'b0};
			5'd9:  u = '{OP_MUL,  R_SN,   R_CS,   R_SC,   1'b1, 1'b0};
			5'd10: u = '{OP_MUL,  R_CS,   R_CS,   R_C2,   1'b1, 1'b0};
			5'd11: u = '{OP_MUL,  R_ABSV, R_K0,   R_T0,   1'b0, 1'b0};
			5'd12: u = '{OP_MUL,  R_T0,   R_INTG, R_T0,   1'b0, 1'b0};
			5'd13: u = '{OP_MUL,  R_T0,   R_C2,   R_T1,   1'b1, 1'b1};
			5'd14: u = '{OP_MUL,  R_SDOT, R_K2,   R_T0,   1'b0, 1'b0};
			5'd15: u = '{OP_MUL,  R_T0,   R_D,    R_T0,   1'b0, 1'b0};
			5'd16: u = '{OP_MUL,  R_T0,   R_C2,   R_T2,   1'b1, 1'b1};
			5'd17: u = '{OP_MUL,  R_DDOT, R_C,    R_T0,   1'b0, 1'b0};
			5'd18: u = '{OP_MUL,  R_D,    R_CR,   R_T3,   1'b0, 1'b0};
			5'd19: u = '{OP_MUL,  R_T3,   R_SDOT, R_T3,   1'b0, 1'b0};
			5'd20: u = '{OP_ADD,  R_T0,   R_T3,   R_T0,   1'b0, 1'b0};
			5'd21: u = '{OP_MUL,  R_T0,   R_SC,   R_T0,   1'b1, 1'b0};
			5'd22: u = '{OP_ADD,  R_T1,   R_T2,   R_T1,   1'b0, 1'b0};
			5'd23: u = '{OP_ADD,  R_T1,   R_T0,   R_T1,   1'b0, 1'b0};
			5'd24: u = '{OP_DIV,  R_T1,   R_DEN,  R_T1,   1'b0, 1'b0};
			5'd25: u = '{OP_MUL,  R_ABSV, R_K3,   R_T0,   1'b0, 1'b0};
			5'd26: u = '{OP_MUL,  R_T0,   R_SC,   R_T0,   1'b1, 1'b1};
			5'd27: u = '{OP_ADD,  R_T1,   R_T0,   R_T1,   1'b0, 1'b0};
			5'd28: u = '{OP_MUL,  R_SDOT, R_C,    R_T0,   1'b0, 1'b0};
			5'd29: u = '{OP_ADD,  R_T1,   R_T0,   R_T1,   1'b0, 1'b0};
			default: u = '{OP_END, R_T0, R_T0, R_T0, 1'b0, 1'b0};
		endcase
		return u;
	endfunction

endpackage

// ===== hw/rtl/cfpf_cordic.sv =====
// ----------------------------------------------------------------------------
// cfpf_cordic - iterative sine/cosine
// rotation-mode cordic in q30, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module cfpf_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [18:0] ang,
	output logic               done,
	output logic signed [63:0] sn,
	output logic signed [63:0] cs
);

	logic              busy_q;
	logic              done_q;
	logic [4:0]        i_q;
	logic signed [35:0] x_q, y_q, z_q;
	logic              flip_q;
	logic signed [63:0] sn_q, cs_q;

	logic signed [35:0] z0, z1, z2;
	logic              flip0;
	logic signed [35:0] xs, ys, at, xn, yn, zn;
	logic              dir;

	// range reduction to plus or minus pi/2 with a half-turn flip
	always_comb begin
		z0 = 36'(ang) <<< (30 - cfpf_pkg::FRAC_BITS);
		if (z0 > cfpf_pkg::Q30_PI)
			z1 = z0 - cfpf_pkg::Q30_TWO_PI;
		else if (z0 < -cfpf_pkg::Q30_PI)
			z1 = z0 + cfpf_pkg::Q30_TWO_PI;
		else
			z1 = z0;
		flip0 = 1'b0;
		z2 = z1;
		if (z1 > cfpf_pkg::Q30_HALF_PI) begin
			z2 = z1 - cfpf_pkg::Q30_PI;
			flip0 = 1'b1;
		end else if (z1 < -cfpf_pkg::Q30_HALF_PI) begin
			z2 = z1 + cfpf_pkg::Q30_PI;
			flip0 = 1'b1;
		end
	end

	always_comb begin
		dir = !z_q[35];
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = 36'(cfpf_pkg::ATAN_Q30[i_q]);
		xn = dir ? (x_q - ys) : (x_q + ys);
		yn = dir ? (y_q + xs) : (y_q - xs);
		zn = dir ? (z_q - at) : (z_q + at);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(cfpf_pkg::NITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= cfpf_pkg::Q30_GAIN;
			y_q    <= '0;
			z_q    <= z2;
			flip_q <= flip0;
		end else if (busy_q) begin
			x_q <= xn;
			y_q <= yn;
			z_q <= zn;
			if (i_q == 5'(cfpf_pkg::NITER - 1)) begin
				sn_q <= flip_q ? -64'(yn) : 64'(yn);
				cs_q <= flip_q ? -64'(xn) : 64'(xn);
			end
		end
	end

	assign done = done_q;
	assign sn   = sn_q;
	assign cs   = cs_q;

endmodule

// ===== hw/rtl/cfpf_mul.sv =====
// ----------------------------------------------------------------------------
// cfpf_mul - iterative scaled multiplier
// signed 64x64 product from four 32x32 partials, shifted, truncated, clamped
// ----------------------------------------------------------------------------
module cfpf_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   a,
	input  logic signed [63:0]   b,
	input  logic                 sh30,
	output cfpf_pkg::unit_rsp_t  rsp
);

	logic         busy_q;
	logic         done_q;
	logic [2:0]   cnt_q;
	logic         neg_q;
	logic         sh30_q;
	logic [63:0]  ua_q, ub_q;
	logic [63:0]  p_q;
	logic [1:0]   off_q;
	logic [127:0] acc_q;
	logic signed [63:0] res_q;
	logic         sat_q;

	logic [31:0]  opa, opb;
	logic [127:0] shifted;
	logic [63:0]  mres;
	logic         ovf;

	assign opa = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign opb = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];

	always_comb begin
		shifted = sh30_q ? (acc_q >> 30) : (acc_q >> cfpf_pkg::FRAC_BITS);
		ovf = (|shifted[127:64]) || (shifted[63:0] > 64'(cfpf_pkg::LIM_POS));
		mres = ovf ? 64'(cfpf_pkg::LIM_POS) : shifted[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= a[63] ^ b[63];
			ua_q   <= cfpf_pkg::mag64(a);
			ub_q   <= cfpf_pkg::mag64(b);
			sh30_q <= sh30;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q <= 3'd3) begin
				p_q   <= opa * opb;
				off_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				acc_q <= acc_q + ({64'd0, p_q} << {off_q, 5'd0});
			if (cnt_q == 3'd5) begin
				res_q <= neg_q ? -$signed(mres) : $signed(mres);
				sat_q <= ovf;
			end
		end
	end

	assign rsp = '{done: done_q, sat: sat_q, res: res_q};

endmodule

// ===== hw/rtl/cfpf_div.sv =====
// ----------------------------------------------------------------------------
// cfpf_div - iterative fixed point divider
// restoring division of (a << frac) by b, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cfpf_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   a,
	input  logic signed [63:0]   b,
	output cfpf_pkg::unit_rsp_t  rsp
);

	localparam int DB = cfpf_pkg::DIV_BITS;
	localparam int CW = cfpf_pkg::DIV_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [63:0]   ub_q;
	logic [DB-1:0] dvd_q;
	logic [63:0]   rem_q, q_q;
	logic signed [63:0] res_q;
	logic          sat_q;

	logic [63:0] rem_n, q_n, q_fin, ua;
	logic        early, last, fin_sat;

	assign ua = cfpf_pkg::mag64(a);

	always_comb begin
		early = q_q[63:62] != 2'b00;
		last  = cnt_q == CW'(1);
		rem_n = {rem_q[62:0], dvd_q[DB-1]};
		q_n   = {q_q[62:0], 1'b0};
		if (rem_n >= ub_q) begin
			rem_n = rem_n - ub_q;
			q_n   = q_n | 64'd1;
		end
		if (early) begin
			q_fin   = 64'(cfpf_pkg::LIM_POS);
			fin_sat = 1'b1;
		end else if (q_n > 64'(cfpf_pkg::LIM_POS)) begin
			q_fin   = 64'(cfpf_pkg::LIM_POS);
			fin_sat = 1'b1;
		end else begin
			q_fin   = q_n;
			fin_sat = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (early || last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[63] ^ b[63];
			ub_q  <= cfpf_pkg::mag64(b);
			dvd_q <= {ua[61:0], {cfpf_pkg::FRAC_BITS{1'b0}}};
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n;
			q_q   <= q_n;
			dvd_q <= {dvd_q[DB-2:0], 1'b0};
			if (early || last) begin
				res_q <= neg_q ? -$signed(q_fin) : $signed(q_fin);
				sat_q <= fin_sat;
			end
		end
	end

	assign rsp = '{done: done_q, sat: sat_q, res: res_q};

endmodule

// ===== hw/rtl/chained_form_path_follower.sv =====
// ----------------------------------------------------------------------------
// chained_form_path_follower - path following controller with integral
// micro-programmed sequencer over a shared multiplier, divider and cordic
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_stall with speed, distance_error, angle_error,
//   curvature and curvature_rate. one word is taken while in_stall is low;
//   in_stall stays high while a sample is being worked on.
//   output channel: out_valid/out_stall with translation, rotation, status.
//   the result word sits in an output register, so the next sample can be
//   taken while the last result still waits on a stalled receiver.
//   each sample runs the cordic, 19 products on the one 32x32 multiplier,
//   two divisions on the bit-serial divider and add, abs and check steps.
//   a singular denominator ends the sample at the check step. a new sample
//   is taken only after the last result is written; a stalled receiver
//   holds the finished result and the sequencer waits before writing the
//   next one. gains are written on cfg_we/cfg_index/cfg_data, by the user
//   only while the block is idle; the block does not enforce it. reset
//   clears the integral, restores the default gains, empties the output
//   register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module chained_form_path_follower (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// input word
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] speed,
	input  logic signed [31:0] distance_error,
	input  logic signed [18:0] angle_error,
	input  logic signed [31:0] curvature,
	input  logic signed [31:0] curvature_rate,
	// result word
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] translation,
	output logic signed [31:0] rotation,
	output logic [1:0]         status
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_TRIG = 5'b00010,
		S_EXEC = 5'b00100,
		S_WAIT = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [4:0] pc_q;
	logic sat_q, sing_q;
	logic signed [cfpf_pkg::ACC_WIDTH-1:0] integ_q;
	logic [31:0] k0_q, k2_q, k3_q;
	logic out_valid_q;

	// operand registers of the micro-program
	logic signed [31:0] spd_q;
	logic signed [63:0] u1_q, d_q, c_q, cr_q, sn_q, cs_q;
	logic signed [63:0] ddot_q, nums_q, den_q, sdot_q, absv_q, sc_q, c2_q;
	logic signed [63:0] t0_q, t1_q, t2_q, t3_q;
	logic signed [31:0] rot_q;
	logic [1:0]         stat_q;

	cfpf_pkg::uop_t uop;
	logic signed [63:0] opa, opb, sum, wb_val;
	logic wb_en, wb_sat;
	logic accept, out_fire;
	logic cordic_start, cordic_done;
	logic signed [63:0] cordic_sn, cordic_cs;
	logic mul_start, div_start;
	cfpf_pkg::unit_rsp_t mul_rsp, div_rsp;
	logic signed [31:0] rot_n;
	logic               rot_sat;

	assign uop      = cfpf_pkg::ucode(pc_q);
	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && (state_q == S_IDLE);
	assign out_fire = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	assign cordic_start = accept;
	assign mul_start    = (state_q == S_EXEC) && (uop.op == cfpf_pkg::OP_MUL);
	assign div_start    = (state_q == S_EXEC) && (uop.op == cfpf_pkg::OP_DIV);

	cfpf_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.ang    (angle_error),
		.done   (cordic_done),
		.sn     (cordic_sn),
		.cs     (cordic_cs)
	);

	cfpf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (opa),
		.b      (opb),
		.sh30   (uop.sh30),
		.rsp    (mul_rsp)
	);

	cfpf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (opa),
		.b      (opb),
		.rsp    (div_rsp)
	);

	// operand select
	always_comb begin
		case (uop.a)
			cfpf_pkg::R_U1:   opa = u1_q;
			cfpf_pkg::R_D:    opa = d_q;
			cfpf_pkg::R_C:    opa = c_q;
			cfpf_pkg::R_CR:   opa = cr_q;
			cfpf_pkg::R_K0:   opa = 64'(k0_q);
			cfpf_pkg::R_K2:   opa = 64'(k2_q);
			cfpf_pkg::R_K3:   opa = 64'(k3_q);
			cfpf_pkg::R_ONE:  opa = cfpf_pkg::ONE_Q;
			cfpf_pkg::R_INTG: opa = 64'(integ_q);
			cfpf_pkg::R_SN:   opa = sn_q;
			cfpf_pkg::R_CS:   opa = cs_q;
			cfpf_pkg::R_DDOT: opa = ddot_q;
			cfpf_pkg::R_NUMS: opa = nums_q;
			cfpf_pkg::R_DEN:  opa = den_q;
			cfpf_pkg::R_SDOT: opa = sdot_q;
			cfpf_pkg::R_ABSV: opa = absv_q;
			cfpf_pkg::R_SC:   opa = sc_q;
			cfpf_pkg::R_C2:   opa = c2_q;
			cfpf_pkg::R_T0:   opa = t0_q;
			cfpf_pkg::R_T1:   opa = t1_q;
			cfpf_pkg::R_T2:   opa = t2_q;
			cfpf_pkg::R_T3:   opa = t3_q;
			default:          opa = '0;
		endcase
		case (uop.b)
			cfpf_pkg::R_U1:   opb = u1_q;
			cfpf_pkg::R_D:    opb = d_q;
			cfpf_pkg::R_C:    opb = c_q;
			cfpf_pkg::R_CR:   opb = cr_q;
			cfpf_pkg::R_K0:   opb = 64'(k0_q);
			cfpf_pkg::R_K2:   opb = 64'(k2_q);
			cfpf_pkg::R_K3:   opb = 64'(k3_q);
			cfpf_pkg::R_ONE:  opb = cfpf_pkg::ONE_Q;
			cfpf_pkg::R_INTG: opb = 64'(integ_q);
			cfpf_pkg::R_SN:   opb = sn_q;
			cfpf_pkg::R_CS:   opb = cs_q;
			cfpf_pkg::R_DDOT: opb = ddot_q;
			cfpf_pkg::R_NUMS: opb = nums_q;
			cfpf_pkg::R_DEN:  opb = den_q;
			cfpf_pkg::R_SDOT: opb = sdot_q;
			cfpf_pkg::R_ABSV: opb = absv_q;
			cfpf_pkg::R_SC:   opb = sc_q;
			cfpf_pkg::R_C2:   opb = c2_q;
			cfpf_pkg::R_T0:   opb = t0_q;
			cfpf_pkg::R_T1:   opb = t1_q;
			cfpf_pkg::R_T2:   opb = t2_q;
			cfpf_pkg::R_T3:   opb = t3_q;
			default:          opb = '0;
		endcase
	end

	// add and abs ops and unit writeback
	always_comb begin
		wb_en  = 1'b0;
		wb_sat = 1'b0;
		wb_val = '0;
		sum    = opa + opb;
		if (state_q == S_EXEC) begin
			case (uop.op) inside
				cfpf_pkg::OP_ADD, cfpf_pkg::OP_ADDI: begin
					wb_en = 1'b1;
					if (sum > cfpf_pkg::LIM_POS) begin
						wb_val = cfpf_pkg::LIM_POS;
						wb_sat = 1'b1;
					end else if (sum < cfpf_pkg::LIM_NEG) begin
						wb_val = cfpf_pkg::LIM_NEG;
						wb_sat = 1'b1;
					end else begin
						wb_val = sum;
					end
					// the integral also clamps to its own width
					if (uop.op == cfpf_pkg::OP_ADDI) begin
						if (wb_val > cfpf_pkg::ACC_MAX) begin
							wb_val = cfpf_pkg::ACC_MAX;
							wb_sat = 1'b1;
						end else if (wb_val < cfpf_pkg::ACC_MIN) begin
							wb_val = cfpf_pkg::ACC_MIN;
							wb_sat = 1'b1;
						end
					end
				end
				cfpf_pkg::OP_ABS: begin
					wb_en  = 1'b1;
					wb_val = opa[63] ? -opa : opa;
				end
				default: ;
			endcase
		end else if (state_q == S_WAIT) begin
			if (mul_rsp.done) begin
				wb_en  = 1'b1;
				wb_sat = mul_rsp.sat;
				wb_val = uop.neg ? -mul_rsp.res : mul_rsp.res;
			end else if (div_rsp.done) begin
				wb_en  = 1'b1;
				wb_sat = div_rsp.sat;
				wb_val = div_rsp.res;
			end
		end
	end

	// rotation clamp and singular override
	always_comb begin
		rot_sat = 1'b0;
		if (sing_q)
			rot_n = nums_q[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else if (t1_q > cfpf_pkg::I32_MAX) begin
			rot_n   = 32'sh7FFF_FFFF;
			rot_sat = 1'b1;
		end else if (t1_q < cfpf_pkg::I32_MIN) begin
			rot_n   = 32'sh8000_0000;
			rot_sat = 1'b1;
		end else
			rot_n = t1_q[31:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			sat_q       <= 1'b0;
			sing_q      <= 1'b0;
			integ_q     <= '0;
			k0_q        <= '0;
			k2_q        <= 32'(cfpf_pkg::ONE_Q);
			k3_q        <= 32'(cfpf_pkg::ONE_Q);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cfpf_pkg::REG_GAIN_K0: k0_q <= cfg_data;
					cfpf_pkg::REG_GAIN_K2: k2_q <= cfg_data;
					cfpf_pkg::REG_GAIN_K3: k3_q <= cfg_data;
					default: ;
				endcase
			end
			if (wb_en && uop.dst == cfpf_pkg::R_INTG)
				integ_q <= wb_val[cfpf_pkg::ACC_WIDTH-1:0];
			if (wb_sat)
				sat_q <= 1'b1;
			if (out_fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_TRIG;
						sat_q   <= 1'b0;
						sing_q  <= 1'b0;
					end
				end
				S_TRIG: begin
					if (cordic_done) begin
						pc_q    <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (uop.op) inside
						cfpf_pkg::OP_MUL, cfpf_pkg::OP_DIV: state_q <= S_WAIT;
						cfpf_pkg::OP_END: state_q <= S_OUT;
						cfpf_pkg::OP_CHK: begin
							if (den_q == '0) begin
								sing_q  <= 1'b1;
								state_q <= S_OUT;
							end else
								pc_q <= pc_q + 5'd1;
						end
						default: pc_q <= pc_q + 5'd1;
					endcase
				end
				S_WAIT: begin
					if (mul_rsp.done || div_rsp.done) begin
						pc_q    <= pc_q + 5'd1;
						state_q <= S_EXEC;
					end
				end
				S_OUT: begin
					if (out_fire)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operand and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			spd_q <= speed;
			u1_q  <= speed[31] ? -64'(speed) : 64'(speed);
			d_q   <= 64'(distance_error);
			c_q   <= 64'(curvature);
			cr_q  <= 64'(curvature_rate);
		end
		if (cordic_done) begin
			sn_q <= cordic_sn;
			cs_q <= cordic_cs;
		end
		if (wb_en) begin
			case (uop.dst)
				cfpf_pkg::R_DDOT: ddot_q <= wb_val;
				cfpf_pkg::R_NUMS: nums_q <= wb_val;
				cfpf_pkg::R_DEN:  den_q  <= wb_val;
				cfpf_pkg::R_SDOT: sdot_q <= wb_val;
				cfpf_pkg::R_ABSV: absv_q <= wb_val;
				cfpf_pkg::R_SC:   sc_q   <= wb_val;
				cfpf_pkg::R_C2:   c2_q   <= wb_val;
				cfpf_pkg::R_T0:   t0_q   <= wb_val;
				cfpf_pkg::R_T1:   t1_q   <= wb_val;
				cfpf_pkg::R_T2:   t2_q   <= wb_val;
				cfpf_pkg::R_T3:   t3_q   <= wb_val;
				default: ;
			endcase
		end
		if (out_fire) begin
			rot_q  <= rot_n;
			stat_q <= sing_q ? cfpf_pkg::ST_SING :
			          ((sat_q || rot_sat) ? cfpf_pkg::ST_SAT : cfpf_pkg::ST_OK);
		end
	end

	// translation follows the sampled speed
	logic signed [31:0] trans_q;
	always_ff @(posedge clk) begin
		if (out_fire)
			trans_q <= spd_q;
	end

	assign out_valid   = out_valid_q;
	assign translation = trans_q;
	assign rotation    = rot_q;
	assign status      = stat_q;

`ifndef SYNTH
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_rsp.done && div_rsp.done))
		else $error("multiplier and divider finished together");

	a_accept_starts_trig: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_TRIG)
		else $error("accepted word did not start the cordic phase");

	a_out_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result word raised outside the output state");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status == cfpf_pkg::ST_OK || status == cfpf_pkg::ST_SING ||
		                 status == cfpf_pkg::ST_SAT))
		else $error("undefined status code");
`endif

endmodule

// ===== bench/chained_form_path_follower_tb.sv =====
// ----------------------------------------------------------------------------
// chained_form_path_follower_tb - self-checking bench of the path follower
// random and directed samples are predicted in fixed point and every result
// word is compared field by field; gains are changed between phases
// ----------------------------------------------------------------------------
module chained_form_path_follower_tb;

	// one input word as the bench keeps it
	typedef struct packed {
		logic signed [31:0] spd;
		logic signed [31:0] derr;
		logic signed [18:0] ang;
		logic signed [31:0] curv;
		logic signed [31:0] crate;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] trans;
		logic signed [31:0] rot;
		logic [1:0]         st;
	} command_t;

	localparam int STALL_LIMIT = 20000;
	localparam logic signed [63:0] LIMQ = 64'sh3FFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = cfpf_pkg::REG_GAIN_K0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] speed = '0;
	logic signed [31:0] distance_error = '0;
	logic signed [18:0] angle_error = '0;
	logic signed [31:0] curvature = '0;
	logic signed [31:0] curvature_rate = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] translation;
	logic signed [31:0] rotation;
	logic [1:0] status;

	chained_form_path_follower dut (.*);

	always #6 clk = ~clk;

	// predictor state: its own copy of gains and integral
	logic [31:0] k0_gain, k2_gain, k3_gain;
	logic signed [63:0] integ;
	bit clamp_hit;

	sample_t pending_words[$];
	command_t expected_cmds[$];
	int mismatches = 0;
	int accepted_in = 0, accepted_out = 0, singular_seen = 0, sat_seen = 0;
	bit no_idle = 1'b0;      // last part of the run: no bubbles on either side
	bit hold_rx = 1'b0;      // long receiver hold-off request
	int idle_cnt = 0, rx_idle_cnt = 0, hold_cnt = 0, watchdog = 0;

	function automatic logic signed [63:0] clamp62(input logic signed [63:0] v);
		if (v > LIMQ) begin clamp_hit = 1; return LIMQ; end
		if (v < -LIMQ) begin clamp_hit = 1; return -LIMQ; end
		return v;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(clamp62(a)) + 65'(clamp62(b));
		return clamp62(64'(s));
	endfunction

	// exact product, magnitude shifted right, clamped
	function automatic logic signed [63:0] mul_shift(input logic signed [63:0] a,
			input logic signed [63:0] b, input int sh);
		logic [63:0] ua, ub;
		logic [127:0] p;
		bit neg;
		neg = (a < 0) != (b < 0);
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		p = (128'(ua) * 128'(ub)) >> sh;
		if (p > 128'(LIMQ)) begin clamp_hit = 1; p = 128'(LIMQ); end
		return neg ? -$signed(64'(p)) : $signed(64'(p));
	endfunction

	// (a << frac) / b, truncated toward zero, clamped
	function automatic logic signed [63:0] div_q(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [127:0] ua, q;
		logic [63:0] ub;
		bit neg;
		neg = (a < 0) != (b < 0);
		a = clamp62(a);
		b = clamp62(b);
		ua = 128'(a < 0 ? -a : a) << cfpf_pkg::FRAC_BITS;
		ub = b < 0 ? -b : b;
		q = ua / 128'(ub);
		if (q > 128'(LIMQ)) begin clamp_hit = 1; q = 128'(LIMQ); end
		return neg ? -$signed(64'(q)) : $signed(64'(q));
	endfunction

	function automatic logic signed [63:0] shr_floor(input logic signed [63:0] v, input int s);
		return v >>> s;
	endfunction

	function automatic void sin_cos(input logic signed [18:0] ang,
			output logic signed [63:0] sn, output logic signed [63:0] cs);
		logic signed [63:0] z, x, y, t;
		bit flip;
		z = 64'(ang) * (64'sd1 <<< (30 - cfpf_pkg::FRAC_BITS));
		z = z % 64'(cfpf_pkg::Q30_TWO_PI);
		if (z > 64'(cfpf_pkg::Q30_PI)) z -= 64'(cfpf_pkg::Q30_TWO_PI);
		if (z < -64'(cfpf_pkg::Q30_PI)) z += 64'(cfpf_pkg::Q30_TWO_PI);
		flip = 0;
		if (z > 64'(cfpf_pkg::Q30_HALF_PI)) begin
			z -= 64'(cfpf_pkg::Q30_PI); flip = 1;
		end else if (z < -64'(cfpf_pkg::Q30_HALF_PI)) begin
			z += 64'(cfpf_pkg::Q30_PI); flip = 1;
		end
		x = 64'(cfpf_pkg::Q30_GAIN);
		y = 0;
		for (int i = 0; i < cfpf_pkg::NITER; i++) begin
			if (z >= 0) begin
				t = x - shr_floor(y, i); y = y + shr_floor(x, i);
				z -= 64'(cfpf_pkg::ATAN_Q30[i]);
			end else begin
				t = x + shr_floor(y, i); y = y - shr_floor(x, i);
				z += 64'(cfpf_pkg::ATAN_Q30[i]);
			end
			x = t;
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endfunction

	// control law for one sample; updates the integral unless the denominator is singular
	function automatic command_t steer(input sample_t w);
		command_t r;
		logic signed [63:0] u1, d, c, cr, sn, cs, ddot, nums, den, sdot, absv;
		logic signed [63:0] sc, c2, t1, t2, t4, n, u2;
		clamp_hit = 0;
		d = w.derr; c = w.curv; cr = w.crate;
		u1 = w.spd < 0 ? -64'(w.spd) : 64'(w.spd);
		r.trans = w.spd;
		sin_cos(w.ang, sn, cs);
		ddot = mul_shift(u1, sn, 30);
		nums = mul_shift(u1, cs, 30);
		den = sat_add(64'sd1 <<< cfpf_pkg::FRAC_BITS, -mul_shift(d, c, cfpf_pkg::FRAC_BITS));
		if (den == 0) begin
			r.rot = nums >= 0 ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			r.st = cfpf_pkg::ST_SING;
			return r;
		end
		sdot = div_q(nums, den);
		absv = sdot < 0 ? -sdot : sdot;
		integ = sat_add(integ, mul_shift(sdot, d, cfpf_pkg::FRAC_BITS));
		if (integ > cfpf_pkg::ACC_MAX) begin clamp_hit = 1; integ = cfpf_pkg::ACC_MAX; end
		if (integ < cfpf_pkg::ACC_MIN) begin clamp_hit = 1; integ = cfpf_pkg::ACC_MIN; end
		sc = mul_shift(sn, cs, 30);
		c2 = mul_shift(cs, cs, 30);
		t1 = -mul_shift(mul_shift(mul_shift(absv, 64'(k0_gain), cfpf_pkg::FRAC_BITS), integ,
			cfpf_pkg::FRAC_BITS), c2, 30);
		t2 = -mul_shift(mul_shift(mul_shift(sdot, 64'(k2_gain), cfpf_pkg::FRAC_BITS), d,
			cfpf_pkg::FRAC_BITS), c2, 30);
		t4 = mul_shift(sat_add(mul_shift(ddot, c, cfpf_pkg::FRAC_BITS),
			mul_shift(mul_shift(d, cr, cfpf_pkg::FRAC_BITS), sdot, cfpf_pkg::FRAC_BITS)),
			sc, 30);
		n = sat_add(sat_add(t1, t2), t4);
		u2 = div_q(n, den);
		u2 = sat_add(u2, -mul_shift(mul_shift(absv, 64'(k3_gain), cfpf_pkg::FRAC_BITS),
			sc, 30));
		u2 = sat_add(u2, mul_shift(sdot, c, cfpf_pkg::FRAC_BITS));
		if (u2 > cfpf_pkg::I32_MAX) begin clamp_hit = 1; u2 = cfpf_pkg::I32_MAX; end
		if (u2 < cfpf_pkg::I32_MIN) begin clamp_hit = 1; u2 = cfpf_pkg::I32_MIN; end
		r.rot = 32'(u2);
		r.st = clamp_hit ? cfpf_pkg::ST_SAT : cfpf_pkg::ST_OK;
		return r;
	endfunction

	// random sample; mostly moderate magnitudes, some full range
	function automatic sample_t rand_word();
		sample_t w;
		int pick;
		pick = $urandom_range(0, 9);
		w.ang = 19'($signed($urandom_range(0, 411774)) - 205887);
		if (pick < 7) begin
			w.spd = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
			w.derr = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
			w.curv = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
			w.crate = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
		end else begin
			w.spd = $urandom; w.derr = $urandom; w.curv = $urandom; w.crate = $urandom;
		end
		if ($urandom_range(0, 30) == 0) begin
			// d*c of exactly one: singular denominator
			w.derr = 32'sh0002_0000; w.curv = 32'sh0000_8000;
		end
		if ($urandom_range(0, 40) == 0) w.ang = 19'(-205887);
		return w;
	endfunction

	// ------------------------------------------------------------------ driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				accepted_in <= accepted_in + 1;
				expected_cmds.push_back(steer({speed, distance_error, angle_error,
					curvature, curvature_rate}));
			end
			if (!in_valid || !in_stall) begin
				// previous word gone (or none offered): choose what comes next
				if (idle_cnt > 0) begin
					idle_cnt <= idle_cnt - 1;
					in_valid <= 1'b0;
				end else if (!no_idle && $urandom_range(0, 7) == 0) begin
					idle_cnt <= $urandom_range(0, 5);
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					sample_t w;
					w = pending_words.pop_front();
					in_valid <= 1'b1;
					speed <= w.spd; distance_error <= w.derr; angle_error <= w.ang;
					curvature <= w.curv; curvature_rate <= w.crate;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (!arst_n)
			hold_cnt <= 0;
		else if (hold_cnt > 0)
			hold_cnt <= hold_cnt - 1;
		else if (hold_rx)
			hold_cnt <= 1500;
	end

	// ----------------------------------------------------------------- monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				command_t e;
				accepted_out <= accepted_out + 1;
				if (expected_cmds.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("unexpected result word rot=%0d st=%0d",
						rotation, status);
				end else begin
					e = expected_cmds.pop_front();
					if (e.st == cfpf_pkg::ST_SING) singular_seen <= singular_seen + 1;
					if (e.st == cfpf_pkg::ST_SAT) sat_seen <= sat_seen + 1;
					if (translation !== e.trans || rotation !== e.rot || status !== e.st) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: trans %0d/%0d rot %0d/%0d status %0d/%0d",
								translation, e.trans, rotation, e.rot, status, e.st);
					end
				end
			end
			// receiver stalls: long hold-off on request, else random bursts
			if (hold_cnt > 0 || hold_rx) begin
				out_stall <= 1'b1;
			end else if (rx_idle_cnt > 0) begin
				rx_idle_cnt <= rx_idle_cnt - 1;
				out_stall <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 6) == 0) begin
				rx_idle_cnt <= $urandom_range(0, 5);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			// watchdog on cycles without any handshake
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) watchdog <= 0;
			else watchdog <= watchdog + 1;
			if (watchdog >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("chained_form_path_follower_tb NOT OK");
				$finish;
			end
		end
	end

	task automatic drain();
		wait (pending_words.size() == 0);
		while (in_valid || expected_cmds.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_gain(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cfpf_pkg::REG_GAIN_K0: k0_gain = val;
			cfpf_pkg::REG_GAIN_K2: k2_gain = val;
			default:               k3_gain = val;
		endcase
	endtask

	task automatic push(input logic signed [31:0] s, input logic signed [31:0] d,
			input logic signed [18:0] a, input logic signed [31:0] c,
			input logic signed [31:0] cr);
		pending_words.push_back({s, d, a, c, cr});
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin
		k0_gain = 0; k2_gain = 32'h1_0000; k3_gain = 32'h1_0000; integ = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: field extremes, singular denominator, heading near pi/2 and pi
		push(32'sh0001_0000, 32'sh0000_8000, 19'sd0, 32'sh0000_4000, 32'sd0);
		push(-32'sh0001_0000, 32'sh0000_8000, 19'sd51472, 32'sh0000_4000, 32'sh100);
		push(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 19'sd205887, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		push(32'sh8000_0000, 32'sh8000_0000, -19'sd205887, 32'sh8000_0000, 32'sh8000_0000);
		push(32'sh0002_0000, 32'sh0002_0000, 19'sd1000, 32'sh0000_8000, 32'sd5);
		push(-32'sh0002_0000, 32'sh0001_0000, -19'sd1000, 32'sh0001_0000, 32'sd5);
		push(32'sh0001_0000, 32'sh0001_0000, 19'sd102943, 32'sd0, 32'sd0);
		push(32'sh0001_0000, -32'sh0001_0000, -19'sd102944, 32'sd0, 32'sd0);
		push(32'sd0, 32'sd0, 19'sd0, 32'sd0, 32'sd0);
		push(32'sh0003_0000, 32'sh0000_4000, 19'sd205000, 32'sh0001_0000, -32'sh0001_0000);
		push(32'sh0003_0000, 32'sh0000_4000, 19'sh4_0000, 32'sh0001_0000, 32'sd1);
		push(32'sh0003_0000, 32'sh0000_4000, 19'sd262143, 32'sh0001_0000, 32'sd1);
		push(32'sh7FFF_FFFF, 32'sh0000_1000, 19'sd30000, 32'sh0000_0100, 32'sd0);
		drain();

		// phases with different gains, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_gain(cfpf_pkg::REG_GAIN_K0, 32'h0000_8000);
					write_gain(cfpf_pkg::REG_GAIN_K2, 32'h0002_0000);
					write_gain(cfpf_pkg::REG_GAIN_K3, 32'h0001_8000); end
				1: begin write_gain(cfpf_pkg::REG_GAIN_K0, 32'hFFFF_FFFF);
					write_gain(cfpf_pkg::REG_GAIN_K2, 32'hFFFF_FFFF);
					write_gain(cfpf_pkg::REG_GAIN_K3, 32'hFFFF_FFFF); end
				2: begin write_gain(cfpf_pkg::REG_GAIN_K0, 32'd0);
					write_gain(cfpf_pkg::REG_GAIN_K2, 32'd1);
					write_gain(cfpf_pkg::REG_GAIN_K3, 32'd1); end
				default: begin write_gain(cfpf_pkg::REG_GAIN_K0, $urandom & 32'h000F_FFFF);
					write_gain(cfpf_pkg::REG_GAIN_K2, 32'($urandom_range(1, 32'h0004_0000)));
					write_gain(cfpf_pkg::REG_GAIN_K3, 32'($urandom_range(1, 32'h0004_0000)));
				end
			endcase
			if (ph == 5) no_idle = 1'b1;
			for (int i = 0; i < 220; i++) pending_words.push_back(rand_word());
			if (ph == 3) begin
				// receiver holds off while words keep coming, so the block backs up
				wait (accepted_out > 0 && pending_words.size() < 200);
				hold_rx = 1'b1;
				wait (hold_cnt > 0);
				hold_rx = 1'b0;
			end
			drain();
		end

		$display("covered %0d samples over 7 gain settings: %0d singular, %0d saturated",
			accepted_in, singular_seen, sat_seen);
		if (mismatches == 0 && expected_cmds.size() == 0)
			$display("chained_form_path_follower_tb OK");
		else
			$display("chained_form_path_follower_tb NOT OK");
		$finish;
	end

endmodule
